// ===== sv/utf8v_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8v_pkg
// Types and constants shared by the UTF-8 stream validator modules.
// ----------------------------------------------------------------------------
package utf8v_pkg;

   // Error codes reported with every result item
   typedef enum logic [2:0] {
      ERR_OK        = 3'd0,
      ERR_BAD_LEAD  = 3'd1,
      ERR_BAD_CONT  = 3'd2,
      ERR_OVERLONG  = 3'd3,
      ERR_TOO_LARGE = 3'd4,
      ERR_SURROGATE = 3'd5,
      ERR_TRUNCATED = 3'd6
   } err_type;

   // Code point boundaries
   localparam logic [20:0] MIN_TWO_BYTE   = 21'h00080;
   localparam logic [20:0] MIN_THREE_BYTE = 21'h00800;
   localparam logic [20:0] MIN_FOUR_BYTE  = 21'h10000;
   localparam logic [20:0] MAX_BMP        = 21'h0FFFF;
   localparam logic [20:0] MAX_UNICODE    = 21'h10FFFF;
   localparam logic [20:0] SURR_LOW       = 21'h0D800;
   localparam logic [20:0] SURR_HIGH      = 21'h0DFFF;

   // Sequence lengths
   localparam logic [2:0] LEN_ONE   = 3'd1;
   localparam logic [2:0] LEN_TWO   = 3'd2;
   localparam logic [2:0] LEN_THREE = 3'd3;
   localparam logic [2:0] LEN_FOUR  = 3'd4;

   // Continuation byte tag in the two top bits
   localparam logic [1:0] CONT_TAG = 2'b10;

   // Decoder state carried between items
   typedef struct packed {
      logic [1:0]  pending;
      logic [2:0]  seq_len;
      logic [20:0] partial;
   } state_type;

   // One result item
   typedef struct packed {
      logic        char_done;
      logic [20:0] codepoint;
      logic [2:0]  seq_length;
      err_type     error_code;
   } result_type;

endpackage

// ===== sv/utf8_stream_validator_top.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_validator_top
// UTF-8 byte stream decoder and validator, one byte per item.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one raw byte per item in req_tdata, req_tlast on the final
//   byte of a stream. rsp channel: exactly one item per input byte, with
//   rsp_tuser high when that byte completed a valid character, and the code
//   point, its length and an error code in rsp_tdata.
//   csr channel: one write sets bmp_only; write it only while the block is
//   idle. csr_ready is always high.
// Timing:
//   Two register stages: an input register, then the decode step into the
//   result register, which takes the decoded byte once it is free. One byte
//   per cycle is sustained while rsp_tready stays high; the decode state
//   loop closes through the step and the state register.
// Reset:
//   Synchronous reset empties both stages, clears the open sequence and
//   sets bmp_only to 0.
// Stall:
//   When rsp_tready is low the result holds; an empty input register still
//   takes one more byte, after which req_tready drops until the result moves.
// ----------------------------------------------------------------------------
module utf8_stream_validator_top (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_value
   input  logic        req_tlast,   // end_of_stream
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [20:0] codepoint, [23:21] seq_length,
                                    // [26:24] error_code, [31:27] zero
   output logic        rsp_tuser,   // char_done
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data     // bmp_only
);

   logic                  bmp_only_ff;
   logic                  in_valid_ff;
   logic [7:0]            in_byte_ff;
   logic                  in_last_ff;
   logic                  out_valid_ff;
   utf8v_pkg::result_type out_result_ff;
   utf8v_pkg::state_type  state_ff;
   utf8v_pkg::state_type  state_in;
   utf8v_pkg::result_type result_in;
   logic                  out_free;
   logic                  step_fire;
   logic                  req_fire;

   // Handshake
   assign out_free   = !out_valid_ff || rsp_tready;
   assign step_fire  = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         bmp_only_ff <= 1'b0;
      end else if (csr_valid) begin
         bmp_only_ff <= csr_data;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // Decode step
   utf8v_decode u_decode (
      .bmp_only      (bmp_only_ff),
      .byte_value    (in_byte_ff),
      .end_of_stream (in_last_ff),
      .state         (state_ff),
      .state_next    (state_in),
      .result        (result_in)
   );

   // Advance the sequence state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (step_fire) begin
         state_ff <= state_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step_fire) begin
         out_result_ff <= result_in;
      end
   end

   // Drive the result channel
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_result_ff.char_done;
   assign rsp_tdata  = {5'd0, out_result_ff.error_code, out_result_ff.seq_length,
                        out_result_ff.codepoint};

`ifndef NO_ASSERTIONS
   // A completed character carries no error and a real length
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_result_ff.char_done) |->
         (out_result_ff.error_code == utf8v_pkg::ERR_OK &&
          out_result_ff.seq_length != 3'd0))
      else $error("completed character with error or zero length");

   // No character means zero code point and zero length
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_result_ff.char_done) |->
         (out_result_ff.codepoint == 21'd0 && out_result_ff.seq_length == 3'd0))
      else $error("stale code point on result without character");

   // The state is empty after the last byte of a stream
   assert property (@(posedge clock) disable iff (reset)
      (step_fire && in_last_ff) |=> (state_ff == '0))
      else $error("sequence left open after end of stream");

   // An open sequence always has more bytes in total than still pending
   assert property (@(posedge clock) disable iff (reset)
      (state_ff.pending != 2'd0) |-> (state_ff.seq_len > {1'b0, state_ff.pending}))
      else $error("pending count inconsistent with sequence length");
`endif

endmodule

// ===== sv/utf8v_decode.sv =====
// ----------------------------------------------------------------------------
// utf8v_decode
// One UTF-8 decode step: current state and one byte in, next state and one
// result out. Purely combinational.
// ----------------------------------------------------------------------------
module utf8v_decode (
   input  logic                  bmp_only,
   input  logic [7:0]            byte_value,
   input  logic                  end_of_stream,
   input  utf8v_pkg::state_type  state,
   output utf8v_pkg::state_type  state_next,
   output utf8v_pkg::result_type result
);

   logic [20:0]        shifted;
   utf8v_pkg::err_type check_err;

   // Append six payload bits of a continuation byte
   assign shifted = {state.partial[14:0], byte_value[5:0]};

   // Check a finished value: overlong, then too large, then surrogate
   always_comb begin
      check_err = utf8v_pkg::ERR_OK;
      if ((state.seq_len == utf8v_pkg::LEN_TWO   && shifted < utf8v_pkg::MIN_TWO_BYTE)   ||
          (state.seq_len == utf8v_pkg::LEN_THREE && shifted < utf8v_pkg::MIN_THREE_BYTE) ||
          (state.seq_len == utf8v_pkg::LEN_FOUR  && shifted < utf8v_pkg::MIN_FOUR_BYTE)) begin
         check_err = utf8v_pkg::ERR_OVERLONG;
      end else if (shifted > utf8v_pkg::MAX_UNICODE ||
                   (bmp_only && shifted > utf8v_pkg::MAX_BMP)) begin
         check_err = utf8v_pkg::ERR_TOO_LARGE;
      end else if (shifted >= utf8v_pkg::SURR_LOW && shifted <= utf8v_pkg::SURR_HIGH) begin
         check_err = utf8v_pkg::ERR_SURROGATE;
      end
   end

   // Step the sequence
   always_comb begin
      state_next        = state;
      result            = '0;
      result.error_code = utf8v_pkg::ERR_OK;
      if (state.pending == 2'd0) begin
         // Decode a lead byte
         unique case (byte_value) inside
            8'b0???????: begin
               result.char_done  = 1'b1;
               result.codepoint  = {13'd0, byte_value};
               result.seq_length = utf8v_pkg::LEN_ONE;
            end
            8'b110?????: begin
               state_next.seq_len = utf8v_pkg::LEN_TWO;
               state_next.pending = 2'd1;
               state_next.partial = {16'd0, byte_value[4:0]};
            end
            8'b1110????: begin
               state_next.seq_len = utf8v_pkg::LEN_THREE;
               state_next.pending = 2'd2;
               state_next.partial = {17'd0, byte_value[3:0]};
            end
            8'b11110???: begin
               state_next.seq_len = utf8v_pkg::LEN_FOUR;
               state_next.pending = 2'd3;
               state_next.partial = {18'd0, byte_value[2:0]};
            end
            default: begin
               result.error_code = utf8v_pkg::ERR_BAD_LEAD;
            end
         endcase
      end else if (byte_value[7:6] != utf8v_pkg::CONT_TAG) begin
         // Drop the byte and the open sequence
         result.error_code = utf8v_pkg::ERR_BAD_CONT;
         state_next        = '0;
      end else begin
         // Gather a continuation byte
         state_next.partial = shifted;
         state_next.pending = state.pending - 2'd1;
         if (state.pending == 2'd1) begin
            result.error_code = check_err;
            if (check_err == utf8v_pkg::ERR_OK) begin
               result.char_done  = 1'b1;
               result.codepoint  = shifted;
               result.seq_length = state.seq_len;
            end
            state_next = '0;
         end
      end

      // Stream ended with a sequence still open
      if (end_of_stream && state_next.pending != 2'd0) begin
         result.error_code = utf8v_pkg::ERR_TRUNCATED;
         state_next        = '0;
      end
   end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the UTF-8 stream validator. A bit-level decoder
// model predicts one result item per byte; a monitor compares each result,
// field by field, in order. Directed bytes hit the range edges and every
// error kind. Random UTF-8 sequences follow: mostly well formed, some
// overlong, out of range, cut short or noise. Both sides idle in bursts.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_PRINTED = 40;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_data;

   // Decoder model state and its copy of bmp_only
   logic [1:0]  dec_pending;
   logic [2:0]  dec_len;
   logic [20:0] dec_partial;
   logic        dec_bmp_only;

   utf8v_pkg::result_type expected_decodes[$];

   // Idle controls and bookkeeping
   bit          tx_idle_en;
   bit          rx_idle_en;
   int          rx_hold_left;
   int          rx_burst_left;
   int          cycle_count;
   int          mismatch_count;
   int          bytes_sent;
   int          streams_sent;
   int          results_seen;
   int          chars_seen;
   int          err_seen [7];
   int          bmp_writes;

   utf8_stream_validator_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // Free-running clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog on total cycles
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   // Decode one byte in the model and return the result item it causes
   function automatic utf8v_pkg::result_type predict_decode(input logic [7:0] b,
                                                            input logic last);
      utf8v_pkg::result_type r;
      logic [20:0]           v;
      r            = '0;
      r.error_code = utf8v_pkg::ERR_OK;
      if (dec_pending == 2'd0) begin
         if (b[7] == 1'b0) begin
            r.char_done  = 1'b1;
            r.codepoint  = {13'd0, b};
            r.seq_length = utf8v_pkg::LEN_ONE;
         end else if (b[7:5] == 3'b110) begin
            dec_len     = utf8v_pkg::LEN_TWO;
            dec_pending = 2'd1;
            dec_partial = {16'd0, b[4:0]};
         end else if (b[7:4] == 4'b1110) begin
            dec_len     = utf8v_pkg::LEN_THREE;
            dec_pending = 2'd2;
            dec_partial = {17'd0, b[3:0]};
         end else if (b[7:3] == 5'b11110) begin
            dec_len     = utf8v_pkg::LEN_FOUR;
            dec_pending = 2'd3;
            dec_partial = {18'd0, b[2:0]};
         end else begin
            r.error_code = utf8v_pkg::ERR_BAD_LEAD;
         end
      end else if (b[7:6] != utf8v_pkg::CONT_TAG) begin
         // drop the byte and the open sequence
         r.error_code = utf8v_pkg::ERR_BAD_CONT;
         dec_pending  = 2'd0;
         dec_len      = 3'd0;
         dec_partial  = '0;
      end else begin
         dec_partial = {dec_partial[14:0], b[5:0]};
         dec_pending = dec_pending - 2'd1;
         if (dec_pending == 2'd0) begin
            v = dec_partial;
            // overlong first, then range, then surrogate
            if ((dec_len == utf8v_pkg::LEN_TWO && v < utf8v_pkg::MIN_TWO_BYTE) ||
                (dec_len == utf8v_pkg::LEN_THREE && v < utf8v_pkg::MIN_THREE_BYTE) ||
                (dec_len == utf8v_pkg::LEN_FOUR && v < utf8v_pkg::MIN_FOUR_BYTE))
               r.error_code = utf8v_pkg::ERR_OVERLONG;
            else if (v > utf8v_pkg::MAX_UNICODE ||
                     (dec_bmp_only && v > utf8v_pkg::MAX_BMP))
               r.error_code = utf8v_pkg::ERR_TOO_LARGE;
            else if (v >= utf8v_pkg::SURR_LOW && v <= utf8v_pkg::SURR_HIGH)
               r.error_code = utf8v_pkg::ERR_SURROGATE;
            if (r.error_code == utf8v_pkg::ERR_OK) begin
               r.char_done  = 1'b1;
               r.codepoint  = v;
               r.seq_length = dec_len;
            end
            dec_len     = 3'd0;
            dec_partial = '0;
         end
      end
      // end of stream with a sequence still open
      if (last && dec_pending != 2'd0) begin
         r.error_code = utf8v_pkg::ERR_TRUNCATED;
         dec_pending  = 2'd0;
         dec_len      = 3'd0;
         dec_partial  = '0;
      end
      return r;
   endfunction

   // Count one mismatch and print it, up to MAX_PRINTED lines
   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("MISMATCH result %0d: %s got 0x%0h expected 0x%0h",
                  results_seen, what, got, want);
      else if (mismatch_count == MAX_PRINTED + 1)
         $display("further mismatches counted but not printed");
   endtask

   // Send one byte, with an optional idle burst before it
   task automatic send_byte(input logic [7:0] b, input logic last);
      int                    gap;
      utf8v_pkg::result_type want;
      if (tx_idle_en && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      want             = predict_decode(b, last);
      expected_decodes = {expected_decodes, want};
      bytes_sent++;
      if (last)
         streams_sent++;
   endtask

   // Stop sending and wait until every expected result has come back
   task automatic wait_all_decoded();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_decodes.size() != 0);
   endtask

   // Write bmp_only while the block is idle
   task automatic set_bmp_only(input logic value);
      wait_all_decoded();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid    <= 1'b0;
      dec_bmp_only  = value;
      bmp_writes++;
   endtask

   // Send one random sequence: well formed, overlong, out of range, broken or noise
   task automatic send_random_sequence();
      int unsigned kind;
      int unsigned nbytes;
      int unsigned cut;
      logic [20:0] cp;
      logic [7:0]  seq_bytes [4];
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
         send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
         return;
      end
      nbytes = $urandom_range(1, 4);
      case (nbytes)
         1: cp = 21'($urandom_range(0, 'h7F));
         2: cp = (kind < 20) ? 21'($urandom_range(0, 'h7F)) :
                               21'($urandom_range('h80, 'h7FF));
         3: begin
            if (kind < 20)
               cp = 21'($urandom_range(0, 'h7FF));
            else if ($urandom_range(0, 7) == 0)
               cp = 21'($urandom_range('hD800, 'hDFFF));
            else
               cp = 21'($urandom_range('h800, 'hFFFF));
         end
         default: begin
            if (kind < 20)
               cp = 21'($urandom_range(0, 'hFFFF));
            else if (kind < 28)
               cp = 21'($urandom_range('h110000, 'h1FFFFF));
            else
               cp = 21'($urandom_range('h10000, 'h10FFFF));
         end
      endcase
      // encode
      case (nbytes)
         1: seq_bytes[0] = cp[7:0];
         2: begin
            seq_bytes[0] = {3'b110, cp[10:6]};
            seq_bytes[1] = {utf8v_pkg::CONT_TAG, cp[5:0]};
         end
         3: begin
            seq_bytes[0] = {4'b1110, cp[15:12]};
            seq_bytes[1] = {utf8v_pkg::CONT_TAG, cp[11:6]};
            seq_bytes[2] = {utf8v_pkg::CONT_TAG, cp[5:0]};
         end
         default: begin
            seq_bytes[0] = {5'b11110, cp[20:18]};
            seq_bytes[1] = {utf8v_pkg::CONT_TAG, cp[17:12]};
            seq_bytes[2] = {utf8v_pkg::CONT_TAG, cp[11:6]};
            seq_bytes[3] = {utf8v_pkg::CONT_TAG, cp[5:0]};
         end
      endcase
      // corrupt a continuation byte or cut the sequence short
      cut = nbytes;
      if (nbytes > 1 && kind >= 84 && kind < 90)
         seq_bytes[2'($urandom_range(1, nbytes - 1))] = 8'($urandom_range(0, 255));
      else if (nbytes > 1 && kind >= 90)
         cut = $urandom_range(1, nbytes - 1);
      for (int i = 0; i < cut; i++)
         send_byte(seq_bytes[i], $urandom_range(0, 19) == 0);
   endtask

   // Random stream in stretches of 60 bytes, idling chosen per stretch
   task automatic run_random_stream(input int count, input bit idle_allowed);
      int start;
      int stretch_end;
      start = bytes_sent;
      while (bytes_sent - start < count) begin
         tx_idle_en  = idle_allowed && ($urandom_range(0, 2) != 0);
         rx_idle_en  = idle_allowed && ($urandom_range(0, 2) != 0);
         stretch_end = bytes_sent + 60;
         while (bytes_sent < stretch_end && bytes_sent - start < count)
            send_random_sequence();
      end
   endtask

   // Edges of each length, every error kind, cut-short and bad byte at the end
   task automatic test_directed_chars();
      logic [8:0] steps [26] = '{
         9'h000, 9'h07F,                  // ASCII range edges
         9'h0C2, 9'h080,                  // smallest two-byte
         9'h0EF, 9'h0BF, 9'h0BF,          // largest BMP
         9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,  // largest code point
         9'h080, 9'h0FF,                  // stray continuation, invalid lead
         9'h0C1, 9'h0BF,                  // overlong two-byte
         9'h0F4, 9'h090, 9'h080, 9'h080,  // above the limit
         9'h0ED, 9'h0A0, 9'h080,          // surrogate
         9'h0E2, 9'h141,                  // bad continuation on the last byte
         9'h0F0, 9'h19F                   // stream ends inside a sequence
      };
      tx_idle_en = 1'b1;
      rx_idle_en = 1'b1;
      foreach (steps[i])
         send_byte(steps[i][7:0], steps[i][8]);
   endtask

   // BMP-only mode rejects a four-byte character, then a random stream runs in that mode
   task automatic test_bmp_limit();
      set_bmp_only(1'b1);
      send_byte(8'hF0, 1'b0);
      send_byte(8'h90, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h80, 1'b0);
      run_random_stream(300, 1'b1);
   endtask

   // Full range mode
   task automatic test_full_range();
      set_bmp_only(1'b0);
      run_random_stream(300, 1'b1);
   endtask

   // Long receiver hold-off while bytes keep coming, then a full pause
   task automatic test_backpressure();
      tx_idle_en   = 1'b0;
      rx_idle_en   = 1'b0;
      rx_hold_left = 50;
      run_random_stream(60, 1'b0);
      wait_all_decoded();
   endtask

   // Closing stretch in BMP-only mode with no idling on either side
   task automatic test_steady_stream();
      set_bmp_only(1'b1);
      tx_idle_en = 1'b0;
      rx_idle_en = 1'b0;
      run_random_stream(250, 1'b0);
   endtask

   // Drive rsp_tready: long hold first, then random idle bursts
   always @(posedge clock) begin
      if (rx_hold_left > 0) begin
         rsp_tready <= 1'b0;
         rx_hold_left--;
      end else if (rx_burst_left > 0) begin
         rsp_tready <= 1'b0;
         rx_burst_left--;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
         rsp_tready    <= 1'b0;
         rx_burst_left  = $urandom_range(0, 6);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin : check_results
      utf8v_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_decodes.size() == 0) begin
            report_mismatch("result with nothing expected", rsp_tdata, 0);
         end else begin
            want = expected_decodes.pop_front();
            if (rsp_tuser !== want.char_done)
               report_mismatch("char_done", 32'(rsp_tuser), 32'(want.char_done));
            if (rsp_tdata[20:0] !== want.codepoint)
               report_mismatch("codepoint", 32'(rsp_tdata[20:0]), 32'(want.codepoint));
            if (rsp_tdata[23:21] !== want.seq_length)
               report_mismatch("seq_length", 32'(rsp_tdata[23:21]), 32'(want.seq_length));
            if (rsp_tdata[26:24] !== want.error_code)
               report_mismatch("error_code", 32'(rsp_tdata[26:24]), 32'(want.error_code));
            if (rsp_tdata[31:27] !== 5'd0)
               report_mismatch("tdata padding", 32'(rsp_tdata[31:27]), 0);
            if (want.char_done)
               chars_seen++;
            err_seen[want.error_code]++;
         end
         results_seen++;
      end
   end

   // Reset, run the tests in turn, drain and report
   initial begin : run_tests
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = 8'd0;
      req_tlast      = 1'b0;
      rsp_tready     = 1'b0;
      csr_valid      = 1'b0;
      csr_data       = 1'b0;
      dec_pending    = 2'd0;
      dec_len        = 3'd0;
      dec_partial    = '0;
      dec_bmp_only   = 1'b0;
      tx_idle_en     = 1'b0;
      rx_idle_en     = 1'b0;
      rx_hold_left   = 0;
      rx_burst_left  = 0;
      mismatch_count = 0;
      bytes_sent     = 0;
      streams_sent   = 0;
      results_seen   = 0;
      chars_seen     = 0;
      bmp_writes     = 0;
      foreach (err_seen[i])
         err_seen[i] = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_chars();
      test_bmp_limit();
      test_full_range();
      test_backpressure();
      test_steady_stream();

      wait_all_decoded();
      repeat (10) @(posedge clock);
      if (expected_decodes.size() != 0)
         report_mismatch("results never arrived", 0, expected_decodes.size());

      $display("Covered %0d bytes in %0d marked streams, %0d bmp_only writes, %0d characters",
               bytes_sent, streams_sent, bmp_writes, chars_seen);
      $display("Errors seen: lead %0d, cont %0d, overlong %0d, large %0d, surr %0d, cut %0d",
               err_seen[utf8v_pkg::ERR_BAD_LEAD], err_seen[utf8v_pkg::ERR_BAD_CONT],
               err_seen[utf8v_pkg::ERR_OVERLONG], err_seen[utf8v_pkg::ERR_TOO_LARGE],
               err_seen[utf8v_pkg::ERR_SURROGATE], err_seen[utf8v_pkg::ERR_TRUNCATED]);
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== files.f =====
sv/utf8v_pkg.sv
sv/utf8v_decode.sv
sv/utf8_stream_validator_top.sv
verif/testbench.sv
